FILE: rtl/wpm_pkg.sv
// Package for the wildcard pattern matcher: widths, request kinds, symbols
// and the star-closure function shared by the step logic and the top level.
// No dependencies.
package wpm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int POS_W       = PATTERN_MAX + 1;
  localparam int IDX_W       = 5;
  localparam int LEN_W       = 6;
  localparam int SYM_W       = 8;
  localparam int CLOSE_LVLS  = $clog2(POS_W);

  localparam logic [SYM_W-1:0] SYM_ANY_ONE = 8'h3F;
  localparam logic [SYM_W-1:0] SYM_ANY_RUN = 8'h2A;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_NAME  = 2'd1,
    OP_EMPTY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [POS_W-1:0] next_live;
    logic             has_result;
    logic             matched;
  } step_t;

  // Closure over stars: position j+1 becomes live when j is live and
  // prop[j] (a star in use at j). Log-depth prefix instead of a ripple.
  function automatic logic [POS_W-1:0] close_stars(input logic [POS_W-1:0] set,
                                                   input logic [PATTERN_MAX-1:0] prop);
    logic [POS_W-1:0] g;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] g_n;
    logic [POS_W-1:0] p_n;
    int               span;
    g = set;
    p = {prop, 1'b0};
    for (int lvl = 0; lvl < CLOSE_LVLS; lvl++) begin
      span = 1 << lvl;
      g_n  = g;
      p_n  = p;
      for (int j = 0; j < POS_W; j++) begin
        if (j >= span) begin
          g_n[j] = g[j] | (p[j] & g[j-span]);
          p_n[j] = p[j] & p[j-span];
        end
      end
      g = g_n;
      p = p_n;
    end
    return g;
  endfunction

endpackage

FILE: rtl/wpm_step.sv
// One match step: advances the live-position set by one name byte, or restarts it
// for an empty name, and forms the match result. Pure combinational logic.
// Depends on wpm_pkg.
module wpm_step (
  input  logic [wpm_pkg::SYM_W-1:0] pattern [wpm_pkg::PATTERN_MAX],
  input  logic [wpm_pkg::LEN_W-1:0] used_len,
  input  logic [wpm_pkg::POS_W-1:0] live,
  input  wpm_pkg::op_t              op,
  input  logic [wpm_pkg::SYM_W-1:0] sym,
  input  logic                      last,
  output wpm_pkg::step_t            step
);

  logic [wpm_pkg::PATTERN_MAX-1:0] in_len;
  logic [wpm_pkg::PATTERN_MAX-1:0] star_v;
  logic [wpm_pkg::PATTERN_MAX-1:0] hit_v;
  logic [wpm_pkg::POS_W-1:0]       keep;
  logic [wpm_pkg::POS_W-1:0]       closed_in;
  logic [wpm_pkg::POS_W-1:0]       adv;
  logic [wpm_pkg::POS_W-1:0]       closed_out;
  logic [wpm_pkg::POS_W-1:0]       closed_empty;

  always_comb begin
    for (int i = 0; i < wpm_pkg::PATTERN_MAX; i++) begin
      in_len[i] = wpm_pkg::LEN_W'(i) < used_len;
      star_v[i] = in_len[i] && (pattern[i] == wpm_pkg::SYM_ANY_RUN);
      hit_v[i]  = in_len[i] && !star_v[i] &&
                  ((pattern[i] == wpm_pkg::SYM_ANY_ONE) || (pattern[i] == sym));
    end
    for (int j = 0; j < wpm_pkg::POS_W; j++) begin
      keep[j] = wpm_pkg::LEN_W'(j) <= used_len;
    end
  end

  assign closed_in    = wpm_pkg::close_stars(live & keep, star_v);
  // a star keeps its position live, any other hit moves one ahead
  assign adv          = {1'b0, closed_in[wpm_pkg::PATTERN_MAX-1:0] & star_v} |
                        {closed_in[wpm_pkg::PATTERN_MAX-1:0] & hit_v, 1'b0};
  assign closed_out   = wpm_pkg::close_stars(adv, star_v);
  assign closed_empty = wpm_pkg::close_stars(wpm_pkg::POS_W'(1), star_v);

  always_comb begin
    step.next_live  = live;
    step.has_result = 1'b0;
    step.matched    = 1'b0;
    unique case (op)
      wpm_pkg::OP_NAME: begin
        step.has_result = last;
        step.matched    = closed_out[used_len];
        step.next_live  = last ? wpm_pkg::POS_W'(1) : adv;
      end
      wpm_pkg::OP_EMPTY: begin
        step.has_result = 1'b1;
        step.matched    = closed_empty[used_len];
        step.next_live  = wpm_pkg::POS_W'(1);
      end
      default: begin
        step.next_live = live;
      end
    endcase
  end

endmodule

FILE: rtl/wildcard_pattern_matcher.sv
// Glob matcher: a request is registered in the input register on accept, and its
// result (if any) is loaded into the output register when the input register fires;
// a result waits there while the output register is full and not taken. One request
// per cycle while the output is not stalled. Synchronous active-low reset clears the
// length to 0, the live set to position zero and both valid flags; the pattern store
// is not cleared. Depends on wpm_pkg and wpm_step.
module wildcard_pattern_matcher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [4:0] pattern_index, [12:5] symbol, [15:13] zero
  input  logic [1:0]  in_tuser,   // [1:0] op
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] matched, [7:1] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [wpm_pkg::LEN_W-1:0] cfg_data
);

  logic [wpm_pkg::SYM_W-1:0] pattern_r [wpm_pkg::PATTERN_MAX];
  logic [wpm_pkg::LEN_W-1:0] len_r;
  logic [wpm_pkg::LEN_W-1:0] used_len;
  logic [wpm_pkg::POS_W-1:0] live_r;

  logic                      s1_valid_r;
  wpm_pkg::op_t              s1_op_r;
  logic [wpm_pkg::IDX_W-1:0] s1_idx_r;
  logic [wpm_pkg::SYM_W-1:0] s1_sym_r;
  logic                      s1_last_r;

  logic                      out_valid_r;
  logic                      out_matched_r;

  wpm_pkg::step_t            step;
  logic                      out_free;
  logic                      s1_fire;
  logic                      in_fire;

  assign cfg_ready = 1'b1;
  assign used_len  = (len_r > wpm_pkg::LEN_W'(wpm_pkg::PATTERN_MAX)) ?
                     wpm_pkg::LEN_W'(wpm_pkg::PATTERN_MAX) : len_r;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!step.has_result || out_free);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  wpm_step u_step (
    .pattern  (pattern_r),
    .used_len (used_len),
    .live     (live_r),
    .op       (s1_op_r),
    .sym      (s1_sym_r),
    .last     (s1_last_r),
    .step     (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      len_r <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= wpm_pkg::op_t'(in_tuser);
      s1_idx_r  <= in_tdata[4:0];
      s1_sym_r  <= in_tdata[12:5];
      s1_last_r <= in_tlast;
    end
  end

  // pattern store, written from the input register
  always_ff @(posedge clk) begin
    if (s1_fire && (s1_op_r == wpm_pkg::OP_WRITE) &&
        ({1'b0, s1_idx_r} < wpm_pkg::LEN_W'(wpm_pkg::PATTERN_MAX))) begin
      pattern_r[s1_idx_r] <= s1_sym_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= wpm_pkg::POS_W'(1);
    end else if (s1_fire) begin
      live_r <= step.next_live;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && step.has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && step.has_result) begin
      out_matched_r <= step.matched;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_matched_r};

`ifndef ASSERT_OFF
  a_live_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && step.has_result) |=> (live_r == wpm_pkg::POS_W'(1)))
    else $error("live set not restarted after a result");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a blocked result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!(s1_fire && step.has_result) && !(out_valid_r && out_tready)) |=>
      $stable(out_valid_r))
    else $error("result valid changed without a cause");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (s1_op_r == wpm_pkg::OP_WRITE)) |-> !step.has_result)
    else $error("pattern write produced a result");
`endif

endmodule

FILE: bench/tb_wildcard_pattern_matcher.sv
// Self-checking bench for wildcard_pattern_matcher: directed glob cases, then
// random patterns and names with idle and stall bursts on both stream sides.
// Depends on wpm_pkg and the RTL of the matcher.
module tb_wildcard_pattern_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET   = 1500;
  localparam int QUIET_ITEMS   = 250;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 8;

  localparam logic [wpm_pkg::SYM_W-1:0] CH_NUL = 8'h00;
  localparam logic [wpm_pkg::SYM_W-1:0] CH_MAX = 8'hFF;
  localparam logic [wpm_pkg::SYM_W-1:0] CH_A   = 8'h61;
  localparam logic [wpm_pkg::SYM_W-1:0] CH_B   = 8'h62;
  localparam logic [wpm_pkg::SYM_W-1:0] CH_C   = 8'h63;
  localparam logic [wpm_pkg::SYM_W-1:0] CH_Q   = 8'h71;
  localparam logic [wpm_pkg::SYM_W-1:0] CH_X   = 8'h78;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [15:0]       in_tdata;   // [4:0] pattern_index, [12:5] symbol, [15:13] zero
  logic [1:0]        in_tuser;   // [1:0] op
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [7:0]        out_tdata;  // [0] matched, [7:1] zero
  logic              cfg_valid;
  logic              cfg_ready;
  logic [wpm_pkg::LEN_W-1:0] cfg_data;

  // matcher mirror
  logic [wpm_pkg::SYM_W-1:0] pat_mem [wpm_pkg::PATTERN_MAX];
  logic [wpm_pkg::POS_W-1:0] live_set;
  logic [wpm_pkg::LEN_W-1:0] len_reg;
  logic              pending_matches [$];

  logic [wpm_pkg::SYM_W-1:0] name_buf [$];
  int                items_sent;
  int                err_count;
  bit                quiet_tail;
  int                stall_left;

  wildcard_pattern_matcher i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned len_in_use();
    return (len_reg > wpm_pkg::PATTERN_MAX) ? wpm_pkg::PATTERN_MAX : int'(len_reg);
  endfunction

  function automatic void expect_match(input logic m);
    pending_matches = {pending_matches, m};
  endfunction

  function automatic void add_name_byte(input logic [wpm_pkg::SYM_W-1:0] b);
    name_buf = {name_buf, b};
  endfunction

  // A live star at i also makes i+1 live; ascending order chains runs of stars.
  function automatic logic [wpm_pkg::POS_W-1:0] spread_stars(
      input logic [wpm_pkg::POS_W-1:0] set, input int unsigned n);
    for (int i = 0; i < n; i++) begin
      if (set[i] && pat_mem[i] == wpm_pkg::SYM_ANY_RUN) set[i+1] = 1'b1;
    end
    return set;
  endfunction

  task automatic advance_matcher(input wpm_pkg::op_t op,
                                 input logic [wpm_pkg::IDX_W-1:0] idx,
                                 input logic [wpm_pkg::SYM_W-1:0] sym, input logic last);
    int unsigned               n;
    logic [63:0]               keep;
    logic [wpm_pkg::POS_W-1:0] closed;
    logic [wpm_pkg::POS_W-1:0] next;
    n      = len_in_use();
    keep   = (64'd1 << (n + 1)) - 64'd1;
    closed = '0;
    next   = '0;
    case (op)
      wpm_pkg::OP_WRITE: begin
        pat_mem[idx] = sym;
      end
      wpm_pkg::OP_EMPTY: begin
        closed = spread_stars(wpm_pkg::POS_W'(1), n);
        expect_match(closed[n]);
        live_set = wpm_pkg::POS_W'(1);
      end
      wpm_pkg::OP_NAME: begin
        closed = spread_stars(live_set & keep[wpm_pkg::POS_W-1:0], n);
        for (int i = 0; i < n; i++) begin
          if (closed[i]) begin
            if (pat_mem[i] == wpm_pkg::SYM_ANY_RUN) next[i] = 1'b1;
            else if (pat_mem[i] == wpm_pkg::SYM_ANY_ONE || pat_mem[i] == sym)
              next[i+1] = 1'b1;
          end
        end
        if (last) begin
          closed = spread_stars(next, n);
          expect_match(closed[n]);
          live_set = wpm_pkg::POS_W'(1);
        end else begin
          live_set = next;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  // one request on the input stream; entered and left at a falling edge
  task automatic send_item(input wpm_pkg::op_t op, input logic [wpm_pkg::IDX_W-1:0] idx,
                           input logic [wpm_pkg::SYM_W-1:0] sym, input logic last);
    int gap;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    in_tuser  = op;
    in_tdata  = {3'b000, sym, idx};
    in_tlast  = last;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    advance_matcher(op, idx, sym, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (pending_matches.size() != 0) @(negedge clk);
  endtask

  // length register is only touched with the pipeline empty
  task automatic set_length(input logic [wpm_pkg::LEN_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    len_reg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 1) == 0)
      send_item(wpm_pkg::OP_NONE, wpm_pkg::IDX_W'($urandom), wpm_pkg::SYM_W'($urandom),
                1'($urandom));
    else
      send_item(wpm_pkg::OP_WRITE, wpm_pkg::IDX_W'($urandom), wpm_pkg::SYM_W'($urandom),
                1'($urandom));
  endtask

  task automatic send_name(input bit allow_noise);
    if (name_buf.size() == 0) begin
      send_item(wpm_pkg::OP_EMPTY, wpm_pkg::IDX_W'($urandom), wpm_pkg::SYM_W'($urandom),
                1'($urandom));
    end else begin
      foreach (name_buf[i]) begin
        if (allow_noise && $urandom_range(0, 24) == 0) send_noise();
        send_item(wpm_pkg::OP_NAME, wpm_pkg::IDX_W'($urandom), name_buf[i],
                  i == name_buf.size() - 1);
      end
    end
  endtask

  function automatic logic [wpm_pkg::SYM_W-1:0] name_byte();
    if ($urandom_range(0, 9) == 0) return wpm_pkg::SYM_W'($urandom);
    return CH_A + wpm_pkg::SYM_W'($urandom_range(0, 2));
  endfunction

  function automatic logic [wpm_pkg::SYM_W-1:0] pattern_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return wpm_pkg::SYM_ANY_RUN;
    if (r < 5) return wpm_pkg::SYM_ANY_ONE;
    if (r < 9) return CH_A + wpm_pkg::SYM_W'($urandom_range(0, 2));
    return wpm_pkg::SYM_W'($urandom);
  endfunction

  // name that should fit the pattern in use: stars expand to short runs
  task automatic build_fitting_name();
    int run;
    name_buf.delete();
    for (int i = 0; i < len_in_use(); i++) begin
      if (pat_mem[i] == wpm_pkg::SYM_ANY_RUN) begin
        run = $urandom_range(0, 3);
        repeat (run) add_name_byte(name_byte());
      end else if (pat_mem[i] == wpm_pkg::SYM_ANY_ONE) begin
        add_name_byte(name_byte());
      end else begin
        add_name_byte(pat_mem[i]);
      end
    end
  endtask

  task automatic load_name(input logic [wpm_pkg::SYM_W-1:0] bytes [$]);
    name_buf = bytes;
    send_name(1'b0);
  endtask

  // stall bursts on the result side
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else begin
      out_tready = 1'b1;
      if (!quiet_tail && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 6);
    end
  end

  always @(posedge clk) begin
    logic want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_matches.size() == 0) begin
        report_mismatch($sformatf("unexpected result matched=%0b", out_tdata[0]));
      end else begin
        want = pending_matches.pop_front();
        if (out_tdata[0] !== want)
          report_mismatch($sformatf("matched got %0b want %0b", out_tdata[0], want));
      end
    end
  end

  // length 0 after reset: only the empty name matches
  task automatic test_empty_pattern();
    send_item(wpm_pkg::OP_EMPTY, '1, CH_MAX, 1'b1);
    send_item(wpm_pkg::OP_NAME, '0, CH_X, 1'b1);
    send_item(wpm_pkg::OP_NONE, '1, CH_MAX, 1'b1);
    send_item(wpm_pkg::OP_NAME, '0, CH_NUL, 1'b0);
    send_item(wpm_pkg::OP_EMPTY, '0, CH_NUL, 1'b0);
  endtask

  // pattern "*?a": star, single-byte wildcard, literal; star byte in the name
  task automatic test_wildcards();
    send_item(wpm_pkg::OP_WRITE, 5'd0, wpm_pkg::SYM_ANY_RUN, 1'b1);
    send_item(wpm_pkg::OP_WRITE, 5'd1, wpm_pkg::SYM_ANY_ONE, 1'b0);
    send_item(wpm_pkg::OP_WRITE, 5'd2, CH_A, 1'b0);
    send_item(wpm_pkg::OP_WRITE, 5'd31, CH_MAX, 1'b1);
    set_length(wpm_pkg::LEN_W'(3));
    load_name('{CH_X, CH_A});
    load_name('{CH_A});
    load_name('{wpm_pkg::SYM_ANY_RUN, wpm_pkg::SYM_ANY_RUN, CH_A});
    load_name('{CH_MAX, CH_NUL, CH_A});
    name_buf.delete();
    send_name(1'b0);
  endtask

  // length change and pattern write in the middle of a name
  task automatic test_midname_changes();
    send_item(wpm_pkg::OP_NAME, 5'd3, CH_Q, 1'b0);
    set_length(wpm_pkg::LEN_W'(1));
    send_item(wpm_pkg::OP_NAME, 5'd7, CH_NUL, 1'b1);
    send_item(wpm_pkg::OP_NAME, 5'd0, CH_B, 1'b0);
    send_item(wpm_pkg::OP_WRITE, 5'd0, wpm_pkg::SYM_ANY_ONE, 1'b1);
    send_item(wpm_pkg::OP_NAME, 5'd0, CH_C, 1'b1);
  endtask

  task automatic test_random_names();
    logic [wpm_pkg::LEN_W-1:0] len_plan [$];
    logic [wpm_pkg::LEN_W-1:0] len_val;
    int               phase;
    int               n;
    int               names;
    int unsigned      kind;
    len_plan = '{wpm_pkg::LEN_W'(0), wpm_pkg::LEN_W'(1), wpm_pkg::LEN_W'(32),
                 wpm_pkg::LEN_W'(63)};
    phase    = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase < len_plan.size())    len_val = len_plan[phase];
      else if ($urandom_range(0, 3) == 0) len_val = wpm_pkg::LEN_W'($urandom_range(0, 63));
      else                            len_val = wpm_pkg::LEN_W'($urandom_range(0, 8));
      phase++;
      set_length(len_val);
      n = len_in_use();
      // every store entry below the length is written before any name byte
      for (int i = 0; i < n; i++)
        send_item(wpm_pkg::OP_WRITE, wpm_pkg::IDX_W'(i), pattern_byte(), 1'($urandom));
      if (n < wpm_pkg::PATTERN_MAX)
        send_item(wpm_pkg::OP_WRITE,
                  wpm_pkg::IDX_W'($urandom_range(n, wpm_pkg::PATTERN_MAX - 1)),
                  wpm_pkg::SYM_W'($urandom), 1'b0);
      names = $urandom_range(10, 30);
      for (int k = 0; k < names && items_sent < ITEM_TARGET; k++) begin
        if (items_sent > ITEM_TARGET - QUIET_ITEMS) quiet_tail = 1'b1;
        kind = $urandom_range(0, 19);
        if (kind < 12) begin
          build_fitting_name();
        end else if (kind < 14) begin
          build_fitting_name();
          if (name_buf.size() > 0) name_buf[$urandom_range(0, name_buf.size() - 1)] = name_byte();
        end else if (kind < 15) begin
          build_fitting_name();
          if (name_buf.size() > 0) name_buf.delete($urandom_range(0, name_buf.size() - 1));
        end else if (kind < 19) begin
          name_buf.delete();
          repeat ($urandom_range(1, 6)) add_name_byte(name_byte());
        end else begin
          name_buf.delete();
        end
        send_name(1'b1);
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = wpm_pkg::OP_NONE;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    live_set   = wpm_pkg::POS_W'(1);
    len_reg    = '0;
    items_sent = 0;
    err_count  = 0;
    quiet_tail = 1'b0;
    stall_left = 0;
    foreach (pat_mem[i]) pat_mem[i] = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_pattern();
    test_wildcards();
    test_midname_changes();
    test_random_names();

    drain_results();
    repeat (END_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/wpm_pkg.sv
rtl/wpm_step.sv
rtl/wildcard_pattern_matcher.sv
bench/tb_wildcard_pattern_matcher.sv
